>>> sv/mms_pkg.sv
// ============================================================================
// mms_pkg: shared types for the min/max stack
// Opcode and status codes, data width.
// ============================================================================
`default_nettype none

package mms_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

`default_nettype wire

>>> sv/mms_if.sv
// ============================================================================
// mms_if: valid/ready channels of the min/max stack
// Command channel (push/pop) and result channel.
// ============================================================================
`default_nettype none

interface mms_cmd_if
    import mms_pkg::*;
();
    logic                     valid;
    logic                     ready;
    t_opcode                  opcode;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface mms_res_if
    import mms_pkg::*;
#(
    parameter int CW = 9
) ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic signed [DATA_W-1:0] max_value;
    logic [CW-1:0]            entry_count;
    logic                     is_empty;
    t_status                  status;

    modport source (output valid, output top_value, output min_value, output max_value,
                    output entry_count, output is_empty, output status, input ready);
    modport sink   (input valid, input top_value, input min_value, input max_value,
                    input entry_count, input is_empty, input status, output ready);
endinterface

`default_nettype wire

>>> sv/mms_ram.sv
// ============================================================================
// mms_ram: simple dual-port RAM
// One write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module mms_ram #(
    parameter int AW = 8,
    parameter int DW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/min_max_stack.sv
// After a command is accepted, the fill state registers the result word once the
// output register is free. Only one command is in flight: a new one is taken
// after the result of the last has entered the output register; on a pop the
// three RAMs are read (the new top entries are loaded before the result is formed).
// A finished result may wait on the output while the next command is taken.
// Reset clears the three counts and the handshake state; RAM contents are kept.
// ============================================================================
// min_max_stack: LIFO stack of signed words with running minimum and maximum
// Top, min and max are cached in registers; value, min and max stores live in
// three RAMs indexed by their counts.
// ============================================================================
`default_nettype none

module min_max_stack
    import mms_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mms_cmd_if.sink     i_cmd,
    mms_res_if.source   o_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FILL = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_mcnt, n_mcnt;   // min store fill
    logic [CW-1:0] r_xcnt, n_xcnt;   // max store fill

    logic signed [DATA_W-1:0] r_top, r_min, r_max;
    logic signed [DATA_W-1:0] n_top, n_min, n_max;

    // which cached values come from RAM read data in the fill cycle
    logic r_ld_top, r_ld_min, r_ld_max;
    logic n_ld_top, n_ld_min, n_ld_max;
    t_status r_stat, n_stat;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_top, r_out_min, r_out_max;
    logic [CW-1:0]            r_out_count;
    logic                     r_out_empty;
    t_status                  r_out_stat;

    logic accept, out_free, is_push;
    logic v_we, m_we, x_we, rd_en;
    logic [CW-1:0] v_raddr_c, m_raddr_c, x_raddr_c;
    logic [DATA_W-1:0] v_rdata, m_rdata, x_rdata;
    logic signed [DATA_W-1:0] f_top, f_min, f_max;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign is_push     = (i_cmd.opcode == OP_PUSH);
    assign out_free    = !r_out_valid || o_res.ready;

    // command decode and count update in the accept cycle
    always_comb begin
        n_count  = r_count;
        n_mcnt   = r_mcnt;
        n_xcnt   = r_xcnt;
        n_ld_top = 1'b0;
        n_ld_min = 1'b0;
        n_ld_max = 1'b0;
        n_stat   = ST_OK;
        v_we     = 1'b0;
        m_we     = 1'b0;
        x_we     = 1'b0;
        rd_en    = 1'b0;
        if (accept) begin
            if (is_push) begin
                if (r_count == CW'(DEPTH)) begin
                    n_stat = ST_FULL;
                end else begin
                    v_we    = 1'b1;
                    n_count = r_count + CW'(1);
                    if (r_xcnt == '0 || r_max <= i_cmd.push_value) begin
                        x_we   = 1'b1;
                        n_xcnt = r_xcnt + CW'(1);
                    end
                    if (r_mcnt == '0 || i_cmd.push_value <= r_min) begin
                        m_we   = 1'b1;
                        n_mcnt = r_mcnt + CW'(1);
                    end
                end
            end else begin
                if (r_count == '0) begin
                    n_stat = ST_EMPTY;
                end else begin
                    rd_en    = 1'b1;
                    n_count  = r_count - CW'(1);
                    n_ld_top = 1'b1;
                    if (r_min == r_top) begin
                        n_mcnt   = r_mcnt - CW'(1);
                        n_ld_min = 1'b1;
                    end
                    if (r_max == r_top) begin
                        n_xcnt   = r_xcnt - CW'(1);
                        n_ld_max = 1'b1;
                    end
                end
            end
        end
    end

    // entry below the current top; wraps harmlessly when the store empties
    assign v_raddr_c = r_count - CW'(2);
    assign m_raddr_c = r_mcnt - CW'(2);
    assign x_raddr_c = r_xcnt - CW'(2);

    mms_ram #(.AW(AW), .DW(DATA_W)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_cmd.push_value),
        .i_re    (rd_en),
        .i_raddr (v_raddr_c[AW-1:0]),
        .o_rdata (v_rdata)
    );

    mms_ram #(.AW(AW), .DW(DATA_W)) u_min_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (r_mcnt[AW-1:0]),
        .i_wdata (i_cmd.push_value),
        .i_re    (rd_en),
        .i_raddr (m_raddr_c[AW-1:0]),
        .o_rdata (m_rdata)
    );

    mms_ram #(.AW(AW), .DW(DATA_W)) u_max_ram (
        .i_clk   (i_clk),
        .i_we    (x_we),
        .i_waddr (r_xcnt[AW-1:0]),
        .i_wdata (i_cmd.push_value),
        .i_re    (rd_en),
        .i_raddr (x_raddr_c[AW-1:0]),
        .o_rdata (x_rdata)
    );

    // cached top/min/max: pushes update them directly, pops load from RAM
    always_comb begin
        n_top = r_top;
        n_min = r_min;
        n_max = r_max;
        if (accept && is_push && v_we) begin
            n_top = i_cmd.push_value;
            if (m_we) begin
                n_min = i_cmd.push_value;
            end
            if (x_we) begin
                n_max = i_cmd.push_value;
            end
        end
    end

    assign f_top = r_ld_top ? $signed(v_rdata) : r_top;
    assign f_min = r_ld_min ? $signed(m_rdata) : r_min;
    assign f_max = r_ld_max ? $signed(x_rdata) : r_max;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_mcnt      <= '0;
            r_xcnt      <= '0;
            r_ld_top    <= 1'b0;
            r_ld_min    <= 1'b0;
            r_ld_max    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_count  <= n_count;
                r_mcnt   <= n_mcnt;
                r_xcnt   <= n_xcnt;
                r_ld_top <= n_ld_top;
                r_ld_min <= n_ld_min;
                r_ld_max <= n_ld_max;
            end else if (r_state == S_FILL && out_free) begin
                r_ld_top <= 1'b0;
                r_ld_min <= 1'b0;
                r_ld_max <= 1'b0;
            end
            if (r_state == S_FILL && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_top  <= n_top;
            r_min  <= n_min;
            r_max  <= n_max;
            r_stat <= n_stat;
        end else if (r_state == S_FILL && out_free) begin
            r_top <= f_top;
            r_min <= f_min;
            r_max <= f_max;
        end
        if (r_state == S_FILL && out_free) begin
            r_out_top   <= (r_count == '0) ? '0 : f_top;
            r_out_min   <= (r_count == '0) ? '0 : f_min;
            r_out_max   <= (r_count == '0) ? '0 : f_max;
            r_out_count <= r_count;
            r_out_empty <= (r_count == '0);
            r_out_stat  <= r_stat;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.top_value   = r_out_top;
    assign o_res.min_value   = r_out_min;
    assign o_res.max_value   = r_out_max;
    assign o_res.entry_count = r_out_count;
    assign o_res.is_empty    = r_out_empty;
    assign o_res.status      = r_out_stat;

`ifndef ASSERT_OFF
    a_side_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mcnt <= r_count) && (r_xcnt <= r_count))
        else $error("side store deeper than value store");

    a_side_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_count != '0) == (r_mcnt != '0)) && ((r_count != '0) == (r_xcnt != '0)))
        else $error("side store emptiness disagrees with value store");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("command accepted while another is in flight");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == ST_FULL) |-> (o_res.entry_count == CW'(DEPTH)))
        else $error("full status with stack not full");
`endif

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: min/max stack testbench
// Pushes and pops signed words through the command channel with random gaps
// and result back-pressure. A local copy of the stack and its min/max side
// stores predicts every result word, which is checked field by field.
// ============================================================================
`default_nettype none

module tb_top
    import mms_pkg::*;
;

    localparam int DEPTH      = 256;
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int IDLE_LIMIT = 500;

    typedef struct {
        t_opcode                  op;
        logic signed [DATA_W-1:0] val;
    } t_cmd_word;

    typedef struct {
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] min_value;
        logic signed [DATA_W-1:0] max_value;
        logic [CW-1:0]            entry_count;
        logic                     is_empty;
        t_status                  status;
    } t_stack_view;

    logic i_clk;
    logic i_rst_n;

    mms_cmd_if            cmd_if ();
    mms_res_if #(.CW(CW)) res_if ();

    min_max_stack #(.DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    initial begin
        i_rst_n         = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.opcode     = OP_PUSH;
        cmd_if.push_value = '0;
        res_if.ready      = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Stack predictor
    // ------------------------------------------------------------------------
    logic signed [DATA_W-1:0] value_stk [DEPTH];
    logic signed [DATA_W-1:0] min_stk   [DEPTH];
    logic signed [DATA_W-1:0] max_stk   [DEPTH];
    int                       value_n = 0;
    int                       min_n   = 0;
    int                       max_n   = 0;

    function automatic t_stack_view stack_apply(t_opcode op, logic signed [DATA_W-1:0] v);
        t_stack_view              view;
        logic signed [DATA_W-1:0] popped;
        view.status = ST_OK;
        if (op == OP_PUSH) begin
            if (value_n == DEPTH) begin
                view.status = ST_FULL;
            end else begin
                value_stk[value_n] = v;
                value_n++;
                // equal values go on the side stores too, so duplicates pop cleanly
                if (max_n == 0 || v >= max_stk[max_n-1]) begin
                    max_stk[max_n] = v;
                    max_n++;
                end
                if (min_n == 0 || v <= min_stk[min_n-1]) begin
                    min_stk[min_n] = v;
                    min_n++;
                end
            end
        end else begin
            if (value_n == 0) begin
                view.status = ST_EMPTY;
            end else begin
                popped = value_stk[value_n-1];
                if (min_n > 0 && min_stk[min_n-1] == popped) min_n--;
                if (max_n > 0 && max_stk[max_n-1] == popped) max_n--;
                value_n--;
            end
        end
        view.top_value   = '0;
        view.min_value   = '0;
        view.max_value   = '0;
        if (value_n > 0) begin
            view.top_value = value_stk[value_n-1];
            view.min_value = min_stk[min_n-1];
            view.max_value = max_stk[max_n-1];
        end
        view.entry_count = value_n[CW-1:0];
        view.is_empty    = (value_n == 0);
        return view;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    t_cmd_word   pending_cmds [$];
    t_stack_view due_views    [$];
    int          gen_depth   = 0;
    int          cmds_total  = 0;
    int          cmds_done   = 0;
    int          errors      = 0;
    int          idle_cycles = 0;

    function automatic void queue_cmd(t_opcode op, logic signed [DATA_W-1:0] v);
        t_cmd_word w;
        w.op  = op;
        w.val = v;
        pending_cmds.push_back(w);
        if (op == OP_PUSH && gen_depth < DEPTH) gen_depth++;
        if (op == OP_POP && gen_depth > 0) gen_depth--;
    endfunction

    // mix of full-range, clustered (many ties) and extreme values
    function automatic logic signed [DATA_W-1:0] draw_value();
        int sel;
        int near;
        sel = $urandom_range(0, 9);
        if (sel < 4) return $urandom;
        if (sel < 7) begin
            near = $urandom_range(0, 8) - 4;
            return near;
        end
        case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0000_0000;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic void mixed_ops(int n, int push_pct);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < push_pct) queue_cmd(OP_PUSH, draw_value());
            else queue_cmd(OP_POP, '0);
        end
    endfunction

    initial begin
        // directed: empty pop, extremes, ties on both side stores, unwind
        queue_cmd(OP_POP,  32'sh1234_5678);
        queue_cmd(OP_PUSH, 32'sh0000_0000);
        queue_cmd(OP_PUSH, 32'sh7fff_ffff);
        queue_cmd(OP_PUSH, 32'sh8000_0000);
        queue_cmd(OP_PUSH, 32'sh8000_0000);
        queue_cmd(OP_PUSH, 32'sh7fff_ffff);
        queue_cmd(OP_PUSH, 32'sh0000_0005);
        for (int k = 0; k < 7; k++) queue_cmd(OP_POP, '0);
        queue_cmd(OP_PUSH, -32'sd1);
        queue_cmd(OP_PUSH, 32'sh0000_0001);
        queue_cmd(OP_PUSH, 32'sh5555_5555);
        queue_cmd(OP_PUSH, 32'shaaaa_aaaa);
        for (int k = 0; k < 5; k++) queue_cmd(OP_POP, '0);

        mixed_ops(60, 60);
        // fill to capacity, then a few rejected pushes
        while (gen_depth < DEPTH) queue_cmd(OP_PUSH, draw_value());
        for (int k = 0; k < 3; k++) queue_cmd(OP_PUSH, draw_value());
        mixed_ops(30, 50);
        mixed_ops(60, 30);
        cmds_total = pending_cmds.size();

        while (!(cmds_done == cmds_total && due_views.size() == 0)
               && idle_cycles < IDLE_LIMIT)
            @(negedge i_clk);
        if (idle_cycles < IDLE_LIMIT) repeat (8) @(negedge i_clk);

        if (idle_cycles >= IDLE_LIMIT)
            $display("FAIL min_max_stack");
        else if (errors == 0)
            $display("PASS min_max_stack");
        else
            $display("FAIL min_max_stack");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------------
    t_cmd_word cmd_next;
    int        cmd_gap   = 0;
    bit        cmd_burst = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            cmd_gap      <= 0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                due_views.push_back(stack_apply(cmd_if.opcode, cmd_if.push_value));
                cmds_done++;
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (cmd_gap != 0) begin
                    cmd_if.valid <= 1'b0;
                    cmd_gap      <= cmd_gap - 1;
                end else if (pending_cmds.size() != 0) begin
                    cmd_next = pending_cmds.pop_front();
                    cmd_if.valid      <= 1'b1;
                    cmd_if.opcode     <= cmd_next.op;
                    cmd_if.push_value <= cmd_next.val;
                    if ($urandom_range(0, 15) == 0) cmd_burst = !cmd_burst;
                    cmd_gap <= cmd_burst ? 0 : $urandom_range(0, 7);
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    t_stack_view res_exp;
    int          res_stall;
    int          res_wait  = 0;
    bit          res_burst = 1'b0;

    task automatic check_field(string name, logic [DATA_W-1:0] exp, logic [DATA_W-1:0] act);
        if (act !== exp) begin
            $error("%s: expected %h, got %h", name, exp, act);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            res_wait     <= 0;
        end else if (res_if.valid && res_if.ready) begin
            if (due_views.size() == 0) begin
                $error("result word with no command outstanding");
                errors++;
            end else begin
                res_exp = due_views.pop_front();
                check_field("top_value",   res_exp.top_value,   res_if.top_value);
                check_field("min_value",   res_exp.min_value,   res_if.min_value);
                check_field("max_value",   res_exp.max_value,   res_if.max_value);
                check_field("entry_count", res_exp.entry_count, res_if.entry_count);
                check_field("is_empty",    res_exp.is_empty,    res_if.is_empty);
                check_field("status",      res_exp.status,      res_if.status);
            end
            if ($urandom_range(0, 15) == 0) res_burst = !res_burst;
            res_stall = res_burst ? 0 : $urandom_range(0, 7);
            if (res_stall != 0) begin
                res_if.ready <= 1'b0;
                res_wait     <= res_stall - 1;
            end else begin
                res_if.ready <= 1'b1;
            end
        end else if (res_wait != 0) begin
            res_if.ready <= 1'b0;
            res_wait     <= res_wait - 1;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // cycles since the last word moved on either channel
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

`default_nettype wire

>>> sim.f
sv/mms_pkg.sv
sv/mms_if.sv
sv/mms_ram.sv
sv/min_max_stack.sv
test/tb_top.sv
